// ===== design/bdq_pkg.sv =====
// shared types and constants for the bounded deque with delete
`default_nettype none

package bdq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int OPCODE_W       = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_UNSHIFT    = 3'd2,
    OP_SHIFT      = 3'd3,
    OP_DELETE     = 3'd4
  } opcode_t;

  // operation broadcast to every cell, already qualified by full/empty
  typedef struct packed {
    logic push;
    logic unshift;
    logic shift;
    logic del;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== design/bdq_cell.sv =====
// one storage cell of the deque chain: holds a word and hands it to its neighbors
`default_nettype none

module bdq_cell #(
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire bdq_pkg::cell_cmd_t    cmd,
  input  wire logic [DATA_WIDTH-1:0] key,
  input  wire logic                  at_tail,
  input  wire logic                  occupied,
  input  wire logic [DATA_WIDTH-1:0] word_left,
  input  wire logic [DATA_WIDTH-1:0] word_right,
  input  wire logic                  match_in,
  output logic                       match_out,
  output logic [DATA_WIDTH-1:0]      word
);

  // set from the first equal entry onward
  assign match_out = match_in | (occupied && (word == key));

  always_ff @(posedge clk) begin
    if (cmd.unshift) begin
      word <= word_left;
    end else if (cmd.push && at_tail) begin
      word <= key;
    end else if (cmd.shift || (cmd.del && match_out)) begin
      word <= word_right;
    end
  end

endmodule

`default_nettype wire

// ===== design/bounded_deque_with_delete_top.sv =====
// bounded deque with delete by value: a chain of cells plus count and result register
// Usage:
//   Input channel in_valid/in_ready carries opcode and value; output channel
//   out_valid/out_ready carries data_out, occupancy, was_empty, overflow and
//   matched. Every input word gives exactly one output word.
//   Opcodes: push back, pop back, unshift front, shift front, delete first
//   match. The DEPTH cells all compare against value and move their words
//   to a neighbor in the same cycle, so each operation updates the deque in
//   the cycle it is accepted. The result is registered and shows on the
//   output in the cycle after the input word is accepted.
//   Throughput: one word per cycle while the receiver takes results.
//   The single output register is refilled in the cycle it is taken, so the
//   input is ready whenever the output is empty or being taken.
//   Receiver stall: a result waits in the output register and the input
//   stays not ready until that result is taken; nothing is lost.
//   Reset: rst (synchronous) empties the deque and the output register;
//   stored words are not cleared, as only entries below the count are read.
//   A push or unshift into a full deque is dropped and flagged by overflow.
`default_nettype none

module bounded_deque_with_delete_top #(
  parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int IDX_W     = $clog2(DEPTH)
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [bdq_pkg::OPCODE_W-1:0]   opcode,
  input  wire logic [bdq_pkg::VALUE_W-1:0]    value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [bdq_pkg::VALUE_W-1:0]         data_out,
  output logic [CNT_W-1:0]                    occupancy,
  output logic                                was_empty,
  output logic                                overflow,
  output logic                                matched
);

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [DATA_WIDTH-1:0] key;
  logic [DATA_WIDTH-1:0] words [DEPTH];
  logic [DEPTH:0]        match_chain;
  logic [IDX_W-1:0]      tail_idx;
  logic [DATA_WIDTH-1:0] removed;
  logic                  was_empty_next;
  logic                  overflow_next;
  logic                  matched_next;
  bdq_pkg::cell_cmd_t    cmd;
  bdq_pkg::opcode_t      op;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign key      = DATA_WIDTH'(value);
  assign op       = bdq_pkg::opcode_t'(opcode);
  assign tail_idx = IDX_W'(count - CNT_W'(1));

  assign match_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;
    if (i == 0) begin : g_first
      assign left = key;
    end else begin : g_mid_l
      assign left = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = words[i];
    end else begin : g_mid_r
      assign right = words[i+1];
    end
    bdq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .key       (key),
      .at_tail   (count == CNT_W'(i)),
      .occupied  (count > CNT_W'(i)),
      .word_left (left),
      .word_right(right),
      .match_in  (match_chain[i]),
      .match_out (match_chain[i+1]),
      .word      (words[i])
    );
  end

  always_comb begin
    cmd            = '0;
    count_next     = count;
    removed        = '0;
    was_empty_next = 1'b0;
    overflow_next  = 1'b0;
    matched_next   = 1'b0;
    case (op)
      bdq_pkg::OP_PUSH_BACK: begin
        if (full) begin
          overflow_next = 1'b1;
        end else begin
          cmd.push   = accept;
          count_next = count + CNT_W'(1);
        end
      end
      bdq_pkg::OP_POP_BACK: begin
        if (empty) begin
          was_empty_next = 1'b1;
        end else begin
          removed    = words[tail_idx];
          count_next = count - CNT_W'(1);
        end
      end
      bdq_pkg::OP_UNSHIFT: begin
        if (full) begin
          overflow_next = 1'b1;
        end else begin
          cmd.unshift = accept;
          count_next  = count + CNT_W'(1);
        end
      end
      bdq_pkg::OP_SHIFT: begin
        if (empty) begin
          was_empty_next = 1'b1;
        end else begin
          cmd.shift  = accept;
          removed    = words[0];
          count_next = count - CNT_W'(1);
        end
      end
      bdq_pkg::OP_DELETE: begin
        // cells from the first hit onward close the gap on their own
        cmd.del      = accept;
        matched_next = match_chain[DEPTH];
        if (match_chain[DEPTH]) begin
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_out  <= bdq_pkg::VALUE_W'(removed);
      occupancy <= count_next;
      was_empty <= was_empty_next;
      overflow  <= overflow_next;
      matched   <= matched_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_bounded_deque_with_delete_top.sv =====
// testbench for the bounded deque with delete: directed, backpressure and random tests
module tb_bounded_deque_with_delete_top;
  import bdq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 250000;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 300;

  // opcodes the block treats as no operation
  localparam logic [OPCODE_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [VALUE_W-1:0] data_out;
    logic [CNT_W-1:0]   occupancy;
    logic               was_empty;
    logic               overflow;
    logic               matched;
  } deque_result_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic [OPCODE_W-1:0] opcode    = '0;
  logic [VALUE_W-1:0]  value     = '0;
  logic                out_ready = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [VALUE_W-1:0]  data_out;
  logic [CNT_W-1:0]    occupancy;
  logic                was_empty;
  logic                overflow;
  logic                matched;

  bounded_deque_with_delete_top #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out),
    .occupancy (occupancy),
    .was_empty (was_empty),
    .overflow  (overflow),
    .matched   (matched)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow deque, front at index 0
  logic [VALUE_W-1:0] model_words [DEPTH];
  int                 model_count = 0;

  deque_result_t pending_results [$];
  deque_result_t want_result;
  int            fail_count       = 0;
  int            cycle_count      = 0;
  int            send_idle_max    = 12;
  int            recv_idle_max    = 12;
  int            recv_hold_cycles = 0;

  function automatic deque_result_t deque_model_step(input logic [OPCODE_W-1:0] op,
                                                     input logic [VALUE_W-1:0]  val);
    deque_result_t res;
    int            i;
    int            hit;
    res = '0;
    case (op)
      OP_PUSH_BACK: begin
        if (model_count == DEPTH) begin
          res.overflow = 1'b1;
        end else begin
          model_words[model_count] = val;
          model_count++;
        end
      end
      OP_POP_BACK: begin
        if (model_count == 0) begin
          res.was_empty = 1'b1;
        end else begin
          model_count--;
          res.data_out = model_words[model_count];
        end
      end
      OP_UNSHIFT: begin
        if (model_count == DEPTH) begin
          res.overflow = 1'b1;
        end else begin
          for (i = model_count; i > 0; i--) model_words[i] = model_words[i-1];
          model_words[0] = val;
          model_count++;
        end
      end
      OP_SHIFT: begin
        if (model_count == 0) begin
          res.was_empty = 1'b1;
        end else begin
          res.data_out = model_words[0];
          for (i = 1; i < model_count; i++) model_words[i-1] = model_words[i];
          model_count--;
        end
      end
      OP_DELETE: begin
        hit = -1;
        for (i = 0; i < model_count; i++) begin
          if (hit < 0 && model_words[i] == val) hit = i;
        end
        if (hit >= 0) begin
          res.matched = 1'b1;
          for (i = hit + 1; i < model_count; i++) model_words[i-1] = model_words[i];
          model_count--;
        end
      end
      default: begin
      end
    endcase
    res.occupancy = CNT_W'(model_count);
    return res;
  endfunction

  // offer one word after a random gap and hold it until taken
  task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= val;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(deque_model_step(op, val));
  endtask

  initial begin : result_sink
    int gap;
    forever begin
      if (recv_hold_cycles != 0) begin
        gap = recv_hold_cycles;
        recv_hold_cycles = 0;
      end else begin
        gap = $urandom_range(0, recv_idle_max);
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid === 1'b1 && out_ready));
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result word: data=%h occ=%0d empty=%b ovf=%b match=%b",
                   data_out, occupancy, was_empty, overflow, matched);
      end else begin
        want_result = pending_results.pop_front();
        if (data_out !== want_result.data_out || occupancy !== want_result.occupancy ||
            was_empty !== want_result.was_empty || overflow !== want_result.overflow ||
            matched !== want_result.matched) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: expected data=%h occ=%0d empty=%b ovf=%b match=%b, got data=%h occ=%0d empty=%b ovf=%b match=%b",
                     want_result.data_out, want_result.occupancy, want_result.was_empty,
                     want_result.overflow, want_result.matched, data_out, occupancy,
                     was_empty, overflow, matched);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL bounded_deque_with_delete_top");
      $finish;
    end
  end

  task automatic test_directed_cases();
    // removals and delete on an empty deque
    send_word(OP_POP_BACK, 32'h0000_0001);
    send_word(OP_SHIFT, 32'h0000_0002);
    send_word(OP_DELETE, 32'h0000_0000);
    send_word(OP_RSVD_5, 32'hFFFF_FFFF);
    send_word(OP_RSVD_6, 32'h0000_0000);
    send_word(OP_RSVD_7, 32'hA5A5_5A5A);
    send_word(OP_PUSH_BACK, 32'h0000_0000);
    send_word(OP_PUSH_BACK, 32'hFFFF_FFFF);
    send_word(OP_UNSHIFT, 32'hAAAA_AAAA);
    send_word(OP_UNSHIFT, 32'h5555_5555);
    send_word(OP_PUSH_BACK, 32'h1234_5678);
    send_word(OP_UNSHIFT, 32'h1234_5678);
    send_word(OP_RSVD_5, 32'h1234_5678);
    // duplicate value: only the front copy goes
    send_word(OP_DELETE, 32'h1234_5678);
    send_word(OP_DELETE, 32'hDEAD_BEEF);
    send_word(OP_DELETE, 32'h0000_0000);
    send_word(OP_POP_BACK, 32'h0000_0000);
    send_word(OP_SHIFT, 32'h0000_0000);
    send_word(OP_DELETE, 32'hFFFF_FFFF);
    send_word(OP_POP_BACK, 32'h0000_0000);
    send_word(OP_SHIFT, 32'h0000_0000);
    send_word(OP_DELETE, 32'hAAAA_AAAA);
  endtask

  task automatic test_full_and_backpressure();
    logic [VALUE_W-1:0] base;
    int                 i;
    base = $urandom();
    send_idle_max    = 0;
    recv_hold_cycles = HOLD_CYCLES;
    for (i = 0; i <= DEPTH; i++) send_word(OP_PUSH_BACK, base + i);
    send_word(OP_UNSHIFT, 32'hFFFF_FFFF);
    send_word(OP_DELETE, base + 7);
    send_word(OP_UNSHIFT, 32'h0000_0000);
    send_word(OP_PUSH_BACK, base);
    send_word(OP_DELETE, base + DEPTH - 1);
    send_word(OP_DELETE, 32'h0000_0000);
    send_word(OP_UNSHIFT, 32'hFFFF_FFFF);
    for (i = 0; i < DEPTH / 2; i++) send_word(OP_SHIFT, 32'h0000_0000);
    for (i = 0; i <= DEPTH / 2; i++) send_word(OP_POP_BACK, 32'h0000_0000);
    send_word(OP_SHIFT, 32'h0000_0000);
    send_idle_max = 12;
  endtask

  task automatic test_random_mix();
    logic [VALUE_W-1:0]  pool [8];
    logic [OPCODE_W-1:0] op;
    logic [VALUE_W-1:0]  val;
    int                  phase, n, r, tilt;
    int                  t_push, t_unshift, t_pop, t_shift, t_del;
    pool[0] = '0;
    pool[1] = '1;
    for (n = 2; n < 8; n++) pool[n] = $urandom();
    tilt = 0;
    for (phase = 0; phase < 6; phase++) begin
      send_idle_max = (phase == 1 || phase == 3 || phase == 5) ? 0 : 12;
      recv_idle_max = (phase == 1 || phase == 2 || phase == 5) ? 0 : 12;
      for (n = 0; n < 250; n++) begin
        // alternate between filling, draining and balanced stretches
        if (n % 40 == 0) tilt = $urandom_range(0, 2);
        case (tilt)
          0: begin
            t_push = 35; t_unshift = 65; t_pop = 75; t_shift = 85; t_del = 97;
          end
          1: begin
            t_push = 12; t_unshift = 24; t_pop = 50; t_shift = 76; t_del = 97;
          end
          default: begin
            t_push = 20; t_unshift = 40; t_pop = 60; t_shift = 80; t_del = 97;
          end
        endcase
        r = $urandom_range(0, 99);
        if (r < t_push) op = OP_PUSH_BACK;
        else if (r < t_unshift) op = OP_UNSHIFT;
        else if (r < t_pop) op = OP_POP_BACK;
        else if (r < t_shift) op = OP_SHIFT;
        else if (r < t_del) op = OP_DELETE;
        else op = OPCODE_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
        // pool values give repeats so deletes find matches
        if ($urandom_range(0, 9) < 6) val = pool[$urandom_range(0, 7)];
        else val = $urandom();
        send_word(op, val);
      end
    end
    send_idle_max = 12;
    recv_idle_max = 12;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_full_and_backpressure();
    test_random_mix();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS bounded_deque_with_delete_top");
    end else begin
      $display("FAIL bounded_deque_with_delete_top");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bdq_pkg.sv
design/bdq_cell.sv
design/bounded_deque_with_delete_top.sv
tb/tb_bounded_deque_with_delete_top.sv
